// ===== hdl/ssc_pkg.sv =====
package ssc_pkg;

  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 17;
  localparam int unsigned FRAC_BITS  = 16;

  localparam int unsigned PADDR_W = 3;
  localparam logic [PADDR_W-1:0] ADDR_TOL = 3'd0;
  localparam logic [16:0] TOL_RESET = 17'd66;

  localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;
  localparam logic [31:0] MINUS_ONE_Q16 = 32'hffff_0000;
  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

  // per-item fields that ride along with the arithmetic
  typedef struct packed {
    logic             kind;
    logic [2:0][31:0] a;
    logic [2:0]       neg;
    logic [2:0][31:0] m;
    logic [30:0]      ra;
    logic [30:0]      rb;
    logic [31:0]      rsum;
    logic [15:0]      mat_a;
    logic [15:0]      mat_b;
  } side_t;

  typedef struct packed {
    logic             kind;
    logic [2:0][31:0] ca;
    logic [2:0][31:0] cb;
    logic [30:0]      ra;
    logic [30:0]      rb;
    logic [15:0]      mat_a;
    logic [15:0]      mat_b;
  } word_t;

  function automatic logic [31:0] sat32(input logic signed [35:0] v);
    logic [31:0] r;
    if (v > $signed({4'b0, SAT_MAX})) begin
      r = SAT_MAX;
    end else if (v < $signed({4'hf, SAT_MIN})) begin
      r = SAT_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/sphere_sphere_contact_unit.sv =====
// Sphere against sphere contact unit.
// Input channel: one pair of spheres (centers, radii, material ids, kind) per
// word, accepted when in_valid_i is high and in_stall_o is low.
// Output channel: one contact word per overlapping pair, taken when
// out_valid_o is high and out_stall_i is low. Pairs that do not overlap give
// no word; their slot moves on as an empty stage, so a gap shows at the output.
// There are 55 register stages: input differences, squaring multipliers, distance
// compare, a 32-stage square root (one root bit per stage), divider setup, a
// 17-stage divider per axis (one quotient bit per stage), the scaling
// multipliers and the output register.
// Throughput is one pair per cycle; a new pair can enter every clock unless the output stalls.
// When out_stall_i holds a finished word, the whole pipeline freezes and one
// more input word is caught in a skid register; in_stall_o rises the cycle
// after and is a register output.
// Reset clears all valid bits and the skid full flag and sets the tolerance
// register to its default of 66 (Q16.16). The user must write the tolerance over
// the APB port at address 0 only while the unit is idle; the block does not enforce it.
module sphere_sphere_contact_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ssc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        kind_i,
  input  logic [31:0]                 center_a_x_i,
  input  logic [31:0]                 center_a_y_i,
  input  logic [31:0]                 center_a_z_i,
  input  logic [31:0]                 center_b_x_i,
  input  logic [31:0]                 center_b_y_i,
  input  logic [31:0]                 center_b_z_i,
  input  logic [30:0]                 radius_a_i,
  input  logic [30:0]                 radius_b_i,
  input  logic [15:0]                 material_a_in_i,
  input  logic [15:0]                 material_b_in_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [31:0]                 normal_x_o,
  output logic [31:0]                 normal_y_o,
  output logic [31:0]                 normal_z_o,
  output logic [31:0]                 separation_x_o,
  output logic [31:0]                 separation_y_o,
  output logic [31:0]                 separation_z_o,
  output logic [31:0]                 contact_x_o,
  output logic [31:0]                 contact_y_o,
  output logic [31:0]                 contact_z_o,
  output logic [15:0]                 material_a_out_o,
  output logic [15:0]                 material_b_out_o
);

  localparam int unsigned NSQ  = ssc_pkg::SQRT_STEPS;
  localparam int unsigned NDIV = ssc_pkg::DIV_STEPS;
  localparam int unsigned FB   = ssc_pkg::FRAC_BITS;

  // ---------------- configuration ----------------
  logic [16:0] tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= ssc_pkg::TOL_RESET;
    end else if (psel && penable && pwrite && paddr == ssc_pkg::ADDR_TOL) begin
      tol_q <= pwdata[16:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ssc_pkg::ADDR_TOL) ? {15'b0, tol_q} : 32'b0;

  // ---------------- flow control ----------------
  logic out_valid_q;
  logic en;
  logic skid_full_q;
  ssc_pkg::word_t skid_q, in_word, src_word;
  logic src_valid;

  assign en = !(out_valid_q && out_stall_i);
  assign in_stall_o = skid_full_q;

  assign in_word.kind  = kind_i;
  assign in_word.ca    = {center_a_z_i, center_a_y_i, center_a_x_i};
  assign in_word.cb    = {center_b_z_i, center_b_y_i, center_b_x_i};
  assign in_word.ra    = radius_a_i;
  assign in_word.rb    = radius_b_i;
  assign in_word.mat_a = material_a_in_i;
  assign in_word.mat_b = material_b_in_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_full_q <= 1'b0;
    end else if (en) begin
      skid_full_q <= 1'b0;
    end else if (in_valid_i && !skid_full_q) begin
      skid_full_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && in_valid_i && !skid_full_q) begin
      skid_q <= in_word;
    end
  end

  assign src_valid = skid_full_q || in_valid_i;
  assign src_word  = skid_full_q ? skid_q : in_word;

  // ---------------- stage 1: differences ----------------
  logic           s1_v_q;
  ssc_pkg::side_t s1_q, s1_d;

  always_comb begin
    logic signed [32:0] dd;
    s1_d.kind  = src_word.kind;
    s1_d.a     = src_word.ca;
    s1_d.ra    = src_word.ra;
    s1_d.rb    = src_word.rb;
    s1_d.rsum  = {1'b0, src_word.ra} + {1'b0, src_word.rb};
    s1_d.mat_a = src_word.mat_a;
    s1_d.mat_b = src_word.mat_b;
    for (int i = 0; i < 3; i++) begin
      dd = $signed({src_word.cb[i][31], src_word.cb[i]})
         - $signed({src_word.ca[i][31], src_word.ca[i]});
      s1_d.neg[i] = dd[32];
      s1_d.m[i]   = dd[32] ? 32'(-dd) : dd[31:0];
    end
  end

  // ---------------- stage 2: squares ----------------
  logic             s2_v_q;
  ssc_pkg::side_t   s2_q;
  logic [2:0][63:0] s2_sq_q;
  logic [63:0]      s2_rsq_q;

  // ---------------- stage 3: overlap test ----------------
  logic [65:0] dsq_sum;
  assign dsq_sum = {2'b0, s2_sq_q[0]} + {2'b0, s2_sq_q[1]} + {2'b0, s2_sq_q[2]};

  // square root pipe, entry 0 is the stage 3 register
  logic           sq_v_q    [NSQ+1];
  ssc_pkg::side_t sq_side_q [NSQ+1];
  logic [63:0]    sq_n_q    [NSQ+1];
  logic [34:0]    sq_rem_q  [NSQ+1];
  logic [31:0]    sq_root_q [NSQ+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      sq_v_q[0] <= 1'b0;
    end else if (en) begin
      s1_v_q    <= src_valid;
      s2_v_q    <= s1_v_q;
      sq_v_q[0] <= s2_v_q && (dsq_sum < {2'b0, s2_rsq_q});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
      s2_q <= s1_q;
      for (int i = 0; i < 3; i++) begin
        s2_sq_q[i] <= 64'(s1_q.m[i] * s1_q.m[i]);
      end
      s2_rsq_q <= 64'(s1_q.rsum * s1_q.rsum);
      sq_side_q[0] <= s2_q;
      sq_n_q[0]    <= dsq_sum[63:0];
      sq_rem_q[0]  <= '0;
      sq_root_q[0] <= '0;
    end
  end

  for (genvar k = 1; k <= NSQ; k++) begin : g_sqrt
    logic [34:0] rem_sh;
    logic [34:0] trial;

    assign rem_sh = {sq_rem_q[k-1][32:0], sq_n_q[k-1][63:62]};
    assign trial  = {1'b0, sq_root_q[k-1], 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k] <= 1'b0;
      end else if (en) begin
        sq_v_q[k] <= sq_v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_side_q[k] <= sq_side_q[k-1];
        sq_n_q[k]    <= {sq_n_q[k-1][61:0], 2'b00};
        if (rem_sh >= trial) begin
          sq_rem_q[k]  <= rem_sh - trial;
          sq_root_q[k] <= {sq_root_q[k-1][30:0], 1'b1};
        end else begin
          sq_rem_q[k]  <= rem_sh;
          sq_root_q[k] <= {sq_root_q[k-1][30:0], 1'b0};
        end
      end
    end
  end

  // ---------------- divider pipe: u = |d| * 2^16 / distance ----------------
  // entry 0 holds the setup; quotient fits 17 bits since |d| <= distance
  logic             dv_v_q    [NDIV+1];
  ssc_pkg::side_t   dv_side_q [NDIV+1];
  logic [31:0]      dv_dist_q [NDIV+1];
  logic [31:0]      dv_ovl_q  [NDIV+1];
  logic             dv_degen_q[NDIV+1];
  logic [2:0][31:0] dv_rem_q  [NDIV+1];
  logic [2:0][16:0] dv_lo_q   [NDIV+1];
  logic [2:0][16:0] dv_q_q    [NDIV+1];

  logic [31:0] sq_dist;
  assign sq_dist = sq_root_q[NSQ];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (en) begin
      dv_v_q[0] <= sq_v_q[NSQ];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_side_q[0]  <= sq_side_q[NSQ];
      dv_dist_q[0]  <= sq_dist;
      dv_ovl_q[0]   <= sq_side_q[NSQ].rsum - sq_dist;
      dv_degen_q[0] <= !({15'b0, tol_q} < sq_dist);
      for (int i = 0; i < 3; i++) begin
        dv_rem_q[0][i] <= {1'b0, sq_side_q[NSQ].m[i][31:1]};
        dv_lo_q[0][i]  <= {sq_side_q[NSQ].m[i][0], 16'b0};
        dv_q_q[0][i]   <= '0;
      end
    end
  end

  for (genvar k = 1; k <= NDIV; k++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k] <= 1'b0;
      end else if (en) begin
        dv_v_q[k] <= dv_v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      logic [32:0] t;
      if (en) begin
        dv_side_q[k]  <= dv_side_q[k-1];
        dv_dist_q[k]  <= dv_dist_q[k-1];
        dv_ovl_q[k]   <= dv_ovl_q[k-1];
        dv_degen_q[k] <= dv_degen_q[k-1];
        for (int i = 0; i < 3; i++) begin
          t = {dv_rem_q[k-1][i], dv_lo_q[k-1][i][16]};
          dv_lo_q[k][i] <= {dv_lo_q[k-1][i][15:0], 1'b0};
          if (t >= {1'b0, dv_dist_q[k-1]}) begin
            dv_rem_q[k][i] <= 32'(t - {1'b0, dv_dist_q[k-1]});
            dv_q_q[k][i]   <= {dv_q_q[k-1][i][15:0], 1'b1};
          end else begin
            dv_rem_q[k][i] <= t[31:0];
            dv_q_q[k][i]   <= {dv_q_q[k-1][i][15:0], 1'b0};
          end
        end
      end
    end
  end

  // ---------------- scaling multipliers ----------------
  logic             pm_v_q;
  ssc_pkg::side_t   pm_side_q;
  logic             pm_degen_q;
  logic [2:0][16:0] pm_u_q;
  logic [2:0][48:0] pm_sep_q;
  logic [2:0][47:0] pm_con_q;

  // ---------------- output register ----------------
  logic [2:0][31:0] nrm_d, sep_d, con_d, nrm_q, sep_q, con_q;
  logic [15:0]      mat_a_q, mat_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pm_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      pm_v_q      <= dv_v_q[NDIV];
      out_valid_q <= pm_v_q;
    end
  end

  always_comb begin
    logic [31:0]        rr;
    logic signed [35:0] sv, cv, nv;
    rr = pm_side_q.kind ? pm_side_q.rsum : {1'b0, pm_side_q.rb};
    for (int i = 0; i < 3; i++) begin
      sv = $signed({3'b0, pm_sep_q[i][48:FB]});
      cv = $signed({4'b0, pm_con_q[i][47:FB]});
      nv = $signed({19'b0, pm_u_q[i]});
      if (pm_side_q.neg[i]) begin
        sv = -sv;
        cv = -cv;
      end else begin
        nv = -nv;
      end
      cv = cv + $signed({{4{pm_side_q.a[i][31]}}, pm_side_q.a[i]});
      nrm_d[i] = ssc_pkg::sat32(nv);
      sep_d[i] = ssc_pkg::sat32(sv);
      con_d[i] = ssc_pkg::sat32(cv);
    end
    if (pm_degen_q) begin
      nrm_d = {32'b0, ssc_pkg::MINUS_ONE_Q16, 32'b0};
      sep_d = {32'b0, (rr[31] ? ssc_pkg::SAT_MAX : rr), 32'b0};
      con_d = pm_side_q.a;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pm_side_q  <= dv_side_q[NDIV];
      pm_degen_q <= dv_degen_q[NDIV];
      for (int i = 0; i < 3; i++) begin
        pm_u_q[i]   <= dv_q_q[NDIV][i];
        pm_sep_q[i] <= 49'(dv_q_q[NDIV][i] * dv_ovl_q[NDIV]);
        pm_con_q[i] <= 48'(dv_q_q[NDIV][i] * dv_side_q[NDIV].ra);
      end
      nrm_q   <= nrm_d;
      sep_q   <= sep_d;
      con_q   <= con_d;
      mat_a_q <= pm_side_q.mat_a;
      mat_b_q <= pm_side_q.mat_b;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign normal_x_o       = nrm_q[0];
  assign normal_y_o       = nrm_q[1];
  assign normal_z_o       = nrm_q[2];
  assign separation_x_o   = sep_q[0];
  assign separation_y_o   = sep_q[1];
  assign separation_z_o   = sep_q[2];
  assign contact_x_o      = con_q[0];
  assign contact_y_o      = con_q[1];
  assign contact_z_o      = con_q[2];
  assign material_a_out_o = mat_a_q;
  assign material_b_out_o = mat_b_q;

endmodule

// ===== hdl/ssc_checker.sv =====
module ssc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] normal_x_o,
  input logic [31:0] normal_z_o,
  input logic [31:0] contact_x_o
);

  // a stalled word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(contact_x_o))
    else $error("output word changed while stalled");

  // input backpressure only ever follows an output stall
  a_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without output stall");

  // normal components are unit-scale
  a_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(normal_x_o) <= ssc_pkg::ONE_Q16
                     && $signed(normal_x_o) >= -ssc_pkg::ONE_Q16
                     && $signed(normal_z_o) <= ssc_pkg::ONE_Q16
                     && $signed(normal_z_o) >= -ssc_pkg::ONE_Q16))
    else $error("normal out of unit range");

endmodule

bind sphere_sphere_contact_unit ssc_checker u_ssc_checker (.*);
